[rtl/ptcb_pkg.sv]
package ptcb_pkg;

  localparam int MAX_COLUMNS     = 1024;
  localparam int MAX_ENTRIES     = 16384;
  localparam int MAX_COL_ENTRIES = 64;

  localparam int IDX_W   = 10;
  localparam int CNT_W   = 11;
  localparam int VAL_W   = 32;
  localparam int START_W = 15;
  localparam int CS_AW   = 11;
  localparam int ST_AW   = 14;
  localparam int TMP_AW  = 6;
  localparam int NUM_W   = 7;
  localparam int KEY_W   = 22;
  localparam int ENT_W   = IDX_W + VAL_W;

  localparam logic [VAL_W-1:0] Q_ONE = 32'h8000_0000;

  localparam logic [2:0]       ADDR_DIAG_LIMIT  = 3'd0;
  localparam logic [CNT_W-1:0] DIAG_LIMIT_RESET = 11'd1024;

  typedef struct packed {
    logic [IDX_W-1:0] row;
    logic [VAL_W-1:0] val;
  } entry_t;

endpackage

[rtl/ptcb_ram.sv]
module ptcb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ptcb_cfg.sv]
module ptcb_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output logic [ptcb_pkg::CNT_W-1:0] diag_limit
);
  import ptcb_pkg::*;

  logic [CNT_W-1:0] diag_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      diag_limit_r <= DIAG_LIMIT_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_DIAG_LIMIT) begin
      diag_limit_r <= pwdata[CNT_W-1:0];
    end
  end

  assign pready     = 1'b1;
  assign prdata     = (paddr == ADDR_DIAG_LIMIT) ? {{(32-CNT_W){1'b0}}, diag_limit_r} : 32'd0;
  assign diag_limit = diag_limit_r;

endmodule

[rtl/pedigree_t_column_builder.sv]
// Builds one sparse pedigree T column per accepted transfer, in column order from 0. The
// column pointers, the row/value store and a 64-entry column buffer sit in single-port-read
// synchronous RAMs; a sequencer walks the parent columns one store entry at a time, and
// each sire entry is merged by a linear search of the buffer. One item is worked on at a
// time; output stalls hold the sequencer while it emits. Results leave through an output
// register, one entry per transfer, the last flagged by last_entry.
module pedigree_t_column_builder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [9:0]  in_dam_index,
  input  logic        in_dam_known,
  input  logic [9:0]  in_sire_index,
  input  logic        in_sire_known,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [9:0]  out_column_index,
  output logic [9:0]  out_row_index,
  output logic [31:0] out_entry_value,
  output logic        out_empty_column,
  output logic        out_last_entry,
  output logic        out_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ptcb_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CS_A  = 4'd1;
  localparam logic [3:0] S_CS_B  = 4'd2;
  localparam logic [3:0] S_CS_C  = 4'd3;
  localparam logic [3:0] S_ST_RD = 4'd4;
  localparam logic [3:0] S_ST_DT = 4'd5;
  localparam logic [3:0] S_SR_RD = 4'd6;
  localparam logic [3:0] S_SR_CM = 4'd7;
  localparam logic [3:0] S_SIRE  = 4'd8;
  localparam logic [3:0] S_DIAG  = 4'd9;
  localparam logic [3:0] S_CHK   = 4'd10;
  localparam logic [3:0] S_EM_RD = 4'd11;
  localparam logic [3:0] S_EM_LD = 4'd12;
  localparam logic [3:0] S_MARK  = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  localparam logic [1:0] PH_COPY = 2'd0;
  localparam logic [1:0] PH_DAM  = 2'd1;
  localparam logic [1:0] PH_SIRE = 2'd2;

  logic [3:0]         state_r;
  logic [1:0]         phase_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [START_W-1:0] start_r, prev_start_r, r_r, end_r;
  logic [KEY_W-1:0]   prev_key_r, key_r;
  logic               prev_valid_r;
  logic [IDX_W-1:0]   sire_r;
  logic               sk_r;
  logic [NUM_W-1:0]   n_r, cap_r, k_r;
  logic               ovf_r, full_r;
  logic [CS_AW-1:0]   par_r;
  logic               cs_zero_r;
  logic [IDX_W-1:0]   mrow_r;
  logic [VAL_W-1:0]   mval_r;
  logic [CNT_W-1:0]   diag_limit;

  logic               out_valid_r;
  logic [IDX_W-1:0]   out_col_r, out_row_r;
  logic [VAL_W-1:0]   out_val_r;
  logic               out_empty_r, out_last_r, out_ovf_r;

  logic               cs_we;
  logic [CS_AW-1:0]   cs_raddr;
  logic [START_W-1:0] cs_rdata, cs_val;
  logic               st_we;
  entry_t             st_rdata, tmp_rdata, tmp_wdata;
  logic               tmp_we;
  logic [TMP_AW-1:0]  tmp_waddr;

  logic               push_req;
  logic [IDX_W-1:0]   push_row;
  logic [VAL_W-1:0]   push_val;
  logic               merge_we;
  logic [VAL_W:0]     msum;
  logic [VAL_W-1:0]   msat;
  logic               out_free;
  logic               out_load;
  logic [KEY_W-1:0]   in_key;
  logic [START_W-1:0] rem;
  logic [START_W-1:0] new_start;

  ptcb_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .diag_limit
  );

  ptcb_ram #(.WIDTH(START_W), .DEPTH(MAX_COLUMNS + 1)) u_cs_ram (
    .clk, .we(cs_we), .waddr(cnt_r + CNT_W'(1)), .wdata(new_start),
    .raddr(cs_raddr), .rdata(cs_rdata)
  );

  ptcb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_ENTRIES)) u_st_ram (
    .clk, .we(st_we), .waddr(ST_AW'(start_r + START_W'(k_r))), .wdata(tmp_rdata),
    .raddr(r_r[ST_AW-1:0]), .rdata(st_rdata)
  );

  ptcb_ram #(.WIDTH(ENT_W), .DEPTH(MAX_COL_ENTRIES)) u_tmp_ram (
    .clk, .we(tmp_we), .waddr(tmp_waddr), .wdata(tmp_wdata),
    .raddr(k_r[TMP_AW-1:0]), .rdata(tmp_rdata)
  );

  assign cs_val    = cs_zero_r ? '0 : cs_rdata;
  assign new_start = start_r + START_W'(n_r);
  assign cs_we     = (state_r == S_FIN);
  assign cs_raddr  = (state_r == S_CS_B) ? par_r + CS_AW'(1) : par_r;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_load  = out_free && (state_r == S_EM_LD || state_r == S_MARK);
  assign st_we     = (state_r == S_EM_LD) && out_free;
  assign in_key    = {in_dam_known ? in_dam_index : 10'd0, in_dam_known,
                      in_sire_known ? in_sire_index : 10'd0, in_sire_known};
  assign rem       = START_W'(MAX_ENTRIES) - start_r;
  assign msum      = {1'b0, tmp_rdata.val} + {1'b0, mval_r};
  assign msat      = (msum > {1'b0, Q_ONE}) ? Q_ONE : msum[VAL_W-1:0];

  always_comb begin
    push_req = 1'b0;
    push_row = st_rdata.row;
    push_val = st_rdata.val;
    merge_we = 1'b0;
    case (state_r)
      S_ST_DT: begin
        if (phase_r == PH_COPY) begin
          push_req = (st_rdata.row != IDX_W'(cnt_r - CNT_W'(1)));
        end else if (phase_r == PH_DAM) begin
          push_req = 1'b1;
          push_val = st_rdata.val >> 1;
        end
      end
      S_SR_RD: begin
        push_req = (k_r == n_r);
        push_row = mrow_r;
        push_val = mval_r;
      end
      S_SR_CM: merge_we = (tmp_rdata.row == mrow_r);
      S_DIAG: begin
        push_req = (cnt_r < diag_limit);
        push_row = cnt_r[IDX_W-1:0];
        push_val = Q_ONE;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (merge_we) begin
      tmp_we    = 1'b1;
      tmp_waddr = k_r[TMP_AW-1:0];
      tmp_wdata = '{row: mrow_r, val: msat};
    end else begin
      tmp_we    = push_req && (n_r < cap_r);
      tmp_waddr = n_r[TMP_AW-1:0];
      tmp_wdata = '{row: push_row, val: push_val};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      start_r      <= '0;
      prev_start_r <= '0;
      prev_valid_r <= 1'b0;
      prev_key_r   <= '0;
      n_r          <= '0;
      cap_r        <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (push_req) begin
        if (n_r < cap_r) begin
          n_r <= n_r + NUM_W'(1);
        end else begin
          ovf_r <= 1'b1;
        end
      end
      cs_zero_r <= (cs_raddr == '0);
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sire_r <= in_sire_index;
            sk_r   <= in_sire_known;
            key_r  <= in_key;
            n_r    <= '0;
            ovf_r  <= 1'b0;
            cap_r  <= (rem > START_W'(MAX_COL_ENTRIES)) ? NUM_W'(MAX_COL_ENTRIES)
                                                        : NUM_W'(rem);
            full_r <= (cnt_r >= CNT_W'(MAX_COLUMNS));
            par_r  <= {1'b0, in_dam_index};
            if (cnt_r >= CNT_W'(MAX_COLUMNS)) begin
              state_r <= S_MARK;
            end else if (prev_valid_r && in_key == prev_key_r) begin
              phase_r <= PH_COPY;
              r_r     <= prev_start_r;
              end_r   <= start_r;
              state_r <= S_ST_RD;
            end else if (in_dam_known && {1'b0, in_dam_index} < cnt_r) begin
              phase_r <= PH_DAM;
              state_r <= S_CS_A;
            end else begin
              state_r <= S_SIRE;
            end
          end
        end
        S_SIRE: begin
          par_r <= {1'b0, sire_r};
          if (sk_r && {1'b0, sire_r} < cnt_r) begin
            phase_r <= PH_SIRE;
            state_r <= S_CS_A;
          end else begin
            state_r <= S_DIAG;
          end
        end
        S_CS_A: state_r <= S_CS_B;
        S_CS_B: begin
          r_r     <= cs_val;
          state_r <= S_CS_C;
        end
        S_CS_C: begin
          end_r   <= cs_val;
          state_r <= S_ST_RD;
        end
        S_ST_RD: begin
          if (r_r >= end_r) begin
            state_r <= (phase_r == PH_DAM) ? S_SIRE : S_DIAG;
          end else begin
            state_r <= S_ST_DT;
          end
        end
        S_ST_DT: begin
          r_r <= r_r + START_W'(1);
          if (phase_r == PH_SIRE) begin
            mrow_r  <= st_rdata.row;
            mval_r  <= st_rdata.val >> 1;
            k_r     <= '0;
            state_r <= S_SR_RD;
          end else begin
            state_r <= S_ST_RD;
          end
        end
        S_SR_RD: state_r <= (k_r == n_r) ? S_ST_RD : S_SR_CM;
        S_SR_CM: begin
          if (merge_we) begin
            state_r <= S_ST_RD;
          end else begin
            k_r     <= k_r + NUM_W'(1);
            state_r <= S_SR_RD;
          end
        end
        S_DIAG: state_r <= S_CHK;
        S_CHK: begin
          k_r     <= '0;
          state_r <= (n_r == '0) ? S_MARK : S_EM_RD;
        end
        S_EM_RD: state_r <= S_EM_LD;
        S_EM_LD: begin
          if (out_free) begin
            out_col_r   <= cnt_r[IDX_W-1:0];
            out_row_r   <= tmp_rdata.row;
            out_val_r   <= tmp_rdata.val;
            out_empty_r <= 1'b0;
            out_last_r  <= (k_r + NUM_W'(1) == n_r);
            out_ovf_r   <= ovf_r;
            k_r         <= k_r + NUM_W'(1);
            state_r     <= (k_r + NUM_W'(1) == n_r) ? S_FIN : S_EM_RD;
          end
        end
        S_MARK: begin
          if (out_free) begin
            out_col_r   <= cnt_r[IDX_W-1:0];
            out_row_r   <= '0;
            out_val_r   <= '0;
            out_empty_r <= 1'b1;
            out_last_r  <= 1'b1;
            out_ovf_r   <= full_r || ovf_r;
            state_r     <= full_r ? S_IDLE : S_FIN;
          end
        end
        S_FIN: begin
          start_r      <= new_start;
          prev_start_r <= start_r;
          cnt_r        <= cnt_r + CNT_W'(1);
          prev_key_r   <= key_r;
          prev_valid_r <= 1'b1;
          state_r      <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall         = (state_r != S_IDLE);
  assign out_valid        = out_valid_r;
  assign out_column_index = out_col_r;
  assign out_row_index    = out_row_r;
  assign out_entry_value  = out_val_r;
  assign out_empty_column = out_empty_r;
  assign out_last_entry   = out_last_r;
  assign out_overflow     = out_ovf_r;

  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    n_r <= cap_r || state_r == S_IDLE)
    else $error("column buffer fill beyond capacity");

  a_fin_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> cnt_r == $past(cnt_r) + CNT_W'(1))
    else $error("column counter did not advance");

  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty_column |-> out_last_entry)
    else $error("empty marker without last flag");

  a_prev_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    prev_valid_r |-> cnt_r != '0)
    else $error("previous parents valid at column zero");

endmodule

[dv/ptcb_checker.sv]
`timescale 1ns / 1ps

module ptcb_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [9:0]  in_dam_index,
  input  logic        in_dam_known,
  input  logic [9:0]  in_sire_index,
  input  logic        in_sire_known,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [9:0]  out_column_index,
  input  logic [9:0]  out_row_index,
  input  logic [31:0] out_entry_value,
  input  logic        out_empty_column,
  input  logic        out_last_entry,
  input  logic        out_overflow,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending,
  output int          entries_seen
);
  import ptcb_pkg::*;

  typedef struct packed {
    logic [9:0]  col;
    logic [9:0]  row;
    logic [31:0] val;
    logic        empty;
    logic        last;
    logic        ovf;
  } col_entry_t;

  col_entry_t  expected_entries[$];

  logic [CNT_W-1:0] diag_limit_q;
  int               col_start[MAX_COLUMNS+1];
  logic [9:0]       row_mem[MAX_ENTRIES];
  logic [31:0]      val_mem[MAX_ENTRIES];
  logic [KEY_W-1:0] prev_key;
  bit               prev_key_valid;
  int               col_count;

  logic [9:0]  build_row[MAX_COL_ENTRIES];
  logic [31:0] build_val[MAX_COL_ENTRIES];
  int          build_n;
  int          build_cap;
  bit          build_ovf;

  function automatic void add_entry(logic [9:0] row, logic [31:0] val);
    if (build_n < build_cap) begin
      build_row[build_n] = row;
      build_val[build_n] = val;
      build_n++;
    end else begin
      build_ovf = 1'b1;
    end
  endfunction

  function automatic void merge_entry(logic [9:0] row, logic [31:0] val);
    logic [32:0] sum;
    for (int k = 0; k < build_n; k++) begin
      if (build_row[k] == row) begin
        sum = {1'b0, build_val[k]} + {1'b0, val};
        build_val[k] = (sum > {1'b0, Q_ONE}) ? Q_ONE : sum[31:0];
        return;
      end
    end
    add_entry(row, val);
  endfunction

  function automatic void build_column(logic [9:0] dam, logic dk, logic [9:0] sire,
                                       logic sk);
    int               c;
    int               base;
    logic [KEY_W-1:0] key;
    col_entry_t       e;
    c = col_count;
    if (c >= MAX_COLUMNS) begin
      e = '{col: c[9:0], row: '0, val: '0, empty: 1'b1, last: 1'b1, ovf: 1'b1};
      expected_entries.push_back(e);
      return;
    end
    base = col_start[c];
    build_cap = (base < MAX_ENTRIES) ? MAX_ENTRIES - base : 0;
    if (build_cap > MAX_COL_ENTRIES) build_cap = MAX_COL_ENTRIES;
    build_n = 0;
    build_ovf = 1'b0;
    key = {(dk ? dam : 10'd0), dk, (sk ? sire : 10'd0), sk};
    if (prev_key_valid && key == prev_key && c >= 1) begin
      for (int r = col_start[c-1]; r < col_start[c] && r < MAX_ENTRIES; r++)
        if (row_mem[r] != 10'(c - 1)) add_entry(row_mem[r], val_mem[r]);
    end else begin
      if (dk && dam < c)
        for (int r = col_start[dam]; r < col_start[dam+1] && r < MAX_ENTRIES; r++)
          add_entry(row_mem[r], val_mem[r] >> 1);
      if (sk && sire < c)
        for (int r = col_start[sire]; r < col_start[sire+1] && r < MAX_ENTRIES; r++)
          merge_entry(row_mem[r], val_mem[r] >> 1);
    end
    if (c < diag_limit_q) add_entry(10'(c), Q_ONE);
    for (int k = 0; k < build_n; k++) begin
      row_mem[base+k] = build_row[k];
      val_mem[base+k] = build_val[k];
    end
    col_start[c+1] = base + build_n;
    col_count = c + 1;
    prev_key = key;
    prev_key_valid = 1'b1;
    if (build_n == 0) begin
      e = '{col: c[9:0], row: '0, val: '0, empty: 1'b1, last: 1'b1, ovf: build_ovf};
      expected_entries.push_back(e);
    end else begin
      for (int k = 0; k < build_n; k++) begin
        e = '{col: c[9:0], row: build_row[k], val: build_val[k], empty: 1'b0,
              last: (k + 1 == build_n), ovf: build_ovf};
        expected_entries.push_back(e);
      end
    end
  endfunction

  assign pending = expected_entries.size();

  always @(posedge clk) begin
    col_entry_t got;
    col_entry_t want;
    if (!rst_n) begin
      diag_limit_q   <= DIAG_LIMIT_RESET;
      col_start[0]   = 0;
      prev_key_valid = 1'b0;
      col_count      = 0;
      fail_count     = 0;
      entries_seen   = 0;
      expected_entries.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ADDR_DIAG_LIMIT)
        diag_limit_q <= pwdata[CNT_W-1:0];
      if (in_valid && !in_stall)
        build_column(in_dam_index, in_dam_known, in_sire_index, in_sire_known);
      if (out_valid && !out_stall) begin
        got = '{col: out_column_index, row: out_row_index, val: out_entry_value,
                empty: out_empty_column, last: out_last_entry, ovf: out_overflow};
        entries_seen++;
        if (expected_entries.size() == 0) begin
          $display("%0t: unexpected transfer col=%0d row=%0d val=%h", $time,
                   got.col, got.row, got.val);
          fail_count++;
        end else begin
          want = expected_entries.pop_front();
          if (got != want) begin
            $display("%0t: mismatch expected col=%0d row=%0d val=%h empty=%b last=%b ovf=%b",
                     $time, want.col, want.row, want.val, want.empty, want.last, want.ovf);
            $display("%0t:          actual   col=%0d row=%0d val=%h empty=%b last=%b ovf=%b",
                     $time, got.col, got.row, got.val, got.empty, got.last, got.ovf);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ptcb_pkg::*;

  localparam int STALL_LIMIT = 300000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [9:0]  in_dam_index;
  logic        in_dam_known;
  logic [9:0]  in_sire_index;
  logic        in_sire_known;
  logic        out_valid;
  logic        out_stall;
  logic [9:0]  out_column_index;
  logic [9:0]  out_row_index;
  logic [31:0] out_entry_value;
  logic        out_empty_column;
  logic        out_last_entry;
  logic        out_overflow;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int fail_count;
  int pending;
  int entries_seen;
  int columns_sent;
  int idle_cycles;
  bit calm;
  logic [9:0] last_dam;
  logic [9:0] last_sire;
  logic       last_dk;
  logic       last_sk;

  pedigree_t_column_builder u_dut (.*);

  ptcb_checker u_checker (
    .clk, .rst_n, .in_valid, .in_stall, .in_dam_index, .in_dam_known, .in_sire_index,
    .in_sire_known, .out_valid, .out_stall, .out_column_index, .out_row_index,
    .out_entry_value, .out_empty_column, .out_last_entry, .out_overflow,
    .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .fail_count, .pending, .entries_seen
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_column(logic [9:0] dam, logic dk, logic [9:0] sire, logic sk);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_dam_index  <= dam;
    in_dam_known  <= dk;
    in_sire_index <= sire;
    in_sire_known <= sk;
    do @(posedge clk); while (in_stall);
    last_dam = dam;
    last_dk = dk;
    last_sire = sire;
    last_sk = sk;
    columns_sent++;
  endtask

  task automatic write_diag_limit(logic [10:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (20) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_DIAG_LIMIT;
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_random(int count);
    int          c;
    int          pick;
    logic [9:0]  dam;
    logic [9:0]  sire;
    logic        dk;
    logic        sk;
    repeat (count) begin
      c = columns_sent;
      pick = $urandom_range(0, 99);
      dk = 1'b1;
      sk = 1'b1;
      if (pick < 15) begin
        // same parents as the previous individual
        dam = last_dk ? last_dam : 10'($urandom);
        sire = last_sk ? last_sire : 10'($urandom);
        dk = last_dk;
        sk = last_sk;
      end else if (pick < 35 && c >= 2) begin
        // deep lineage grows the column toward its limit
        dam = 10'(c - 1);
        sire = 10'(c - 2);
      end else if (pick < 88 && c >= 1) begin
        dam = 10'(c - 1 - $urandom_range(0, (c > 30) ? 30 : c - 1));
        sire = 10'(c - 1 - $urandom_range(0, (c > 30) ? 30 : c - 1));
        dk = ($urandom_range(0, 9) != 0);
        sk = ($urandom_range(0, 9) != 0);
      end else begin
        dam = 10'($urandom);
        sire = 10'($urandom);
        dk = 1'($urandom);
        sk = 1'($urandom);
      end
      send_column(dam, dk, sire, sk);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    calm = 1'b0;
    columns_sent = 0;
    in_valid = 1'b0;
    in_dam_index = '0;
    in_dam_known = 1'b0;
    in_sire_index = '0;
    in_sire_known = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    last_dam = '0;
    last_sire = '0;
    last_dk = 1'b0;
    last_sk = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_column(10'd0, 1'b0, 10'd0, 1'b0);
    send_column(10'd0, 1'b1, 10'd0, 1'b0);
    send_column(10'd0, 1'b1, 10'd1, 1'b1);
    send_column(10'd0, 1'b1, 10'd1, 1'b1);     // copy of previous column
    send_column(10'd3, 1'b1, 10'd2, 1'b1);
    send_column(10'd1023, 1'b1, 10'd4, 1'b1);  // dam not yet built
    send_column(10'd1023, 1'b0, 10'd1023, 1'b0);
    send_column(10'd5, 1'b0, 10'd512, 1'b0);   // unknown indexes ignored: copy
    send_column(10'd0, 1'b0, 10'd6, 1'b1);
    send_column(10'd8, 1'b1, 10'd8, 1'b1);
    send_column(10'd9, 1'b1, 10'd1022, 1'b1);
    send_column(10'd1, 1'b1, 10'd9, 1'b0);
    send_column(10'd11, 1'b1, 10'd10, 1'b1);
    send_column(10'd12, 1'b1, 10'd11, 1'b1);
    send_column(10'd13, 1'b1, 10'd12, 1'b1);
    send_column(10'd14, 1'b1, 10'd13, 1'b1);
    send_column(10'd15, 1'b1, 10'd14, 1'b1);
    send_column(10'd16, 1'b1, 10'd15, 1'b1);
    send_column(10'd16, 1'b1, 10'd15, 1'b1);
    send_random(130);

    write_diag_limit(11'd0);
    send_column(10'd0, 1'b0, 10'd0, 1'b0);     // empty column
    send_random(50);
    write_diag_limit(11'd1);
    send_random(30);
    write_diag_limit(11'($urandom_range(columns_sent + 20, 700)));
    send_random(80);
    write_diag_limit(11'd1023);
    send_random(50);

    // closing stretch without idling on either side
    write_diag_limit(11'd1024);
    calm = 1'b1;
    send_random(50);
    in_valid <= 1'b0;

    do @(posedge clk); while (pending != 0);
    repeat (50) @(posedge clk);
    $display("columns sent: %0d, column entries checked: %0d", columns_sent, entries_seen);
    $display("diag limit settings: 1024, 0, 1, mid-range, 1023, 1024");
    if (fail_count == 0 && pending == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
